// ===== sv/ckfs_pkg.sv =====
// Shared types and constants of the checkpointed frame stack.
package ckfs_pkg;

  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned OVF_MAX     = 65535;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [0:0] {
    REG_TRACKING_EN = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    FUNC_PUSH   = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_START  = 3'd2,
    FUNC_ABORT  = 3'd3,
    FUNC_COMMIT = 3'd4,
    FUNC_CLEAR  = 3'd5,
    FUNC_READ   = 3'd6
  } func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] entry_tag;
    logic [31:0] checkpoint_id;
    logic [6:0]  read_skip;
  } req_t;

  typedef struct packed {
    logic        frame_valid;
    logic [5:0]  frame_index;
    logic [31:0] frame_tag;
    logic        frame_present;
    logic        last;
    logic [6:0]  stack_depth;
    logic [15:0] overflow_count;
    logic [8:0]  checkpoint_count;
  } rsp_t;

endpackage

// ===== sv/ckfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ckfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ckfs_cfg.sv =====
// APB-style configuration register of the frame stack.
module ckfs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [ckfs_pkg::PADDR_W-1:0]     paddr_i,
  input  logic [ckfs_pkg::DATA_W-1:0]      pwdata_i,
  output logic [ckfs_pkg::DATA_W-1:0]      prdata_o,
  output logic                             pready_o,
  output logic                             tracking_en_o
);

  logic en_q;
  logic sel_en;

  assign sel_en   = (paddr_i[ckfs_pkg::PADDR_W-1] == ckfs_pkg::REG_TRACKING_EN);
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (psel_i && penable_i && pwrite_i && sel_en) begin
      en_q <= pwdata_i[0];
    end
  end

  assign prdata_o      = sel_en ? {{(ckfs_pkg::DATA_W-1){1'b0}}, en_q} : '0;
  assign tracking_en_o = en_q;

endmodule

// ===== sv/checkpointed_frame_stack_top.sv =====
// Checkpointed frame stack: sequencer, state registers and frame/checkpoint stores.
// Push, pop, start, clear and disabled requests: result in the cycle after accept, without busy.
// Read: busy while streaming V visible frames (at most 64), results one per cycle.
// Abort/commit: one checkpoint entry compared per cycle, from the top down.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset clears depth, overflow, checkpoint count, busy and result strobe, and enables tracking.
module checkpointed_frame_stack_top #(
  parameter int unsigned STACK_DEPTH      = 64,
  parameter int unsigned CHECKPOINT_DEPTH = 256,
  parameter int unsigned TAG_BITS         = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  ckfs_pkg::req_t               req_i,
  output logic                         busy_o,
  output logic                         rsp_valid_o,
  output ckfs_pkg::rsp_t               rsp_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [ckfs_pkg::PADDR_W-1:0] paddr_i,
  input  logic [ckfs_pkg::DATA_W-1:0]  pwdata_i,
  output logic [ckfs_pkg::DATA_W-1:0]  prdata_o,
  output logic                         pready_o
);

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CAW = (CHECKPOINT_DEPTH > 1) ? $clog2(CHECKPOINT_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(CHECKPOINT_DEPTH + 1);
  localparam int unsigned VW  = (DW > 7) ? DW : 7;
  localparam int unsigned TW  = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int unsigned CKW = 32 + DW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH
  } state_e;

  state_e state_q, state_d;
  logic [DW-1:0]  depth_q, depth_d;
  logic [15:0]    ovf_q, ovf_d;
  logic [CW-1:0]  ck_top_q, ck_top_d;
  logic           rsp_valid_q, rsp_valid_d;
  ckfs_pkg::rsp_t rsp_q, rsp_d;
  logic [DW-1:0]  cnt_q, cnt_d;
  logic [DW-1:0]  vis_q, vis_d;
  logic [CAW-1:0] ptr_q, ptr_d;
  logic [31:0]    id_q, id_d;
  logic           abort_q, abort_d;

  logic tracking_en;
  logic accept;
  logic do_status;

  logic                fs_we, fs_re;
  logic [AW-1:0]       fs_waddr, fs_raddr;
  logic [TAG_BITS-1:0] fs_wdata, fs_rdata;
  logic                ck_we, ck_re;
  logic [CAW-1:0]      ck_waddr, ck_raddr;
  logic [CKW-1:0]      ck_wdata, ck_rdata;

  logic [VW-1:0] depth_ext, skip_ext, vis_raw;
  logic [DW:0]   cnt_p1;
  logic [CW-1:0] top_m1;
  logic [CAW-1:0] ptr_m1;
  logic [31:0]   rd_tag;

  ckfs_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel_i),
    .penable_i     (penable_i),
    .pwrite_i      (pwrite_i),
    .paddr_i       (paddr_i),
    .pwdata_i      (pwdata_i),
    .prdata_o      (prdata_o),
    .pready_o      (pready_o),
    .tracking_en_o (tracking_en)
  );

  ckfs_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (fs_re),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  ckfs_ram #(
    .WIDTH (CKW),
    .DEPTH (CHECKPOINT_DEPTH)
  ) u_ckpt_ram (
    .clk_i   (clk_i),
    .we_i    (ck_we),
    .waddr_i (ck_waddr),
    .wdata_i (ck_wdata),
    .re_i    (ck_re),
    .raddr_i (ck_raddr),
    .rdata_o (ck_rdata)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign depth_ext = VW'(depth_q);
  assign skip_ext  = VW'(req_i.read_skip);
  assign cnt_p1    = (DW + 1)'(cnt_q) + (DW + 1)'(1);
  assign top_m1    = ck_top_q - CW'(1);
  assign ptr_m1    = ptr_q - CAW'(1);

  always_comb begin
    fs_wdata = '0;
    for (int i = 0; i < TW; i++) begin
      fs_wdata[i] = req_i.entry_tag[i];
    end
    rd_tag = '0;
    for (int i = 0; i < TW; i++) begin
      rd_tag[i] = fs_rdata[i];
    end
  end

  always_comb begin
    vis_raw = (depth_ext > skip_ext) ? (depth_ext - skip_ext) : '0;
    if (vis_raw > VW'(ckfs_pkg::MAX_RESULTS)) begin
      vis_raw = VW'(ckfs_pkg::MAX_RESULTS);
    end
  end

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    ovf_d       = ovf_q;
    ck_top_d    = ck_top_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    cnt_d       = cnt_q;
    vis_d       = vis_q;
    ptr_d       = ptr_q;
    id_d        = id_q;
    abort_d     = abort_q;
    do_status   = 1'b0;
    fs_we       = 1'b0;
    fs_waddr    = depth_q[AW-1:0];
    fs_re       = 1'b0;
    fs_raddr    = '0;
    ck_we       = 1'b0;
    ck_waddr    = ck_top_q[CAW-1:0];
    ck_wdata    = {req_i.checkpoint_id, depth_q};
    ck_re       = 1'b0;
    ck_raddr    = top_m1[CAW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!tracking_en) begin
            do_status = 1'b1;
          end else begin
            case (req_i.func)
              ckfs_pkg::FUNC_PUSH: begin
                do_status = 1'b1;
                if (depth_q < DW'(STACK_DEPTH)) begin
                  fs_we   = 1'b1;
                  depth_d = depth_q + DW'(1);
                end else if (ovf_q < 16'(ckfs_pkg::OVF_MAX)) begin
                  ovf_d = ovf_q + 16'd1;
                end
              end
              ckfs_pkg::FUNC_POP: begin
                do_status = 1'b1;
                if (ovf_q != '0) begin
                  ovf_d = ovf_q - 16'd1;
                end else if (depth_q != '0) begin
                  depth_d = depth_q - DW'(1);
                end
              end
              ckfs_pkg::FUNC_START: begin
                do_status = 1'b1;
                if (ck_top_q < CW'(CHECKPOINT_DEPTH)) begin
                  ck_we    = 1'b1;
                  ck_top_d = ck_top_q + CW'(1);
                end
              end
              ckfs_pkg::FUNC_ABORT, ckfs_pkg::FUNC_COMMIT: begin
                if (ck_top_q == '0) begin
                  do_status = 1'b1;
                end else begin
                  ck_re   = 1'b1;
                  ptr_d   = top_m1[CAW-1:0];
                  id_d    = req_i.checkpoint_id;
                  abort_d = (req_i.func == ckfs_pkg::FUNC_ABORT);
                  state_d = ST_SEARCH;
                end
              end
              ckfs_pkg::FUNC_CLEAR: begin
                do_status = 1'b1;
                depth_d   = '0;
                ovf_d     = '0;
                ck_top_d  = '0;
              end
              ckfs_pkg::FUNC_READ: begin
                if (vis_raw == '0) begin
                  do_status = 1'b1;
                end else begin
                  fs_re    = 1'b1;
                  fs_raddr = '0;
                  cnt_d    = '0;
                  vis_d    = DW'(vis_raw);
                  state_d  = ST_READ;
                end
              end
              default: begin
                do_status = 1'b1;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        fs_re       = 1'b1;
        fs_raddr    = cnt_p1[AW-1:0];
        cnt_d       = cnt_p1[DW-1:0];
        rsp_valid_d = 1'b1;
        rsp_d       = '0;
        rsp_d.frame_valid      = 1'b1;
        rsp_d.frame_index      = 6'(cnt_q);
        rsp_d.frame_tag        = rd_tag;
        rsp_d.frame_present    = (rd_tag != '0);
        rsp_d.last             = (cnt_p1 == (DW + 1)'(vis_q));
        rsp_d.stack_depth      = 7'(depth_q);
        rsp_d.overflow_count   = ovf_q;
        rsp_d.checkpoint_count = 9'(ck_top_q);
        if (rsp_d.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (ck_rdata[CKW-1:DW] == id_q) begin
          do_status = 1'b1;
          ck_top_d  = CW'(ptr_q);
          if (abort_q) begin
            depth_d = ck_rdata[DW-1:0];
          end
          state_d = ST_IDLE;
        end else if (ptr_q == '0) begin
          do_status = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          ck_re    = 1'b1;
          ck_raddr = ptr_m1;
          ptr_d    = ptr_m1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_status) begin
      rsp_valid_d            = 1'b1;
      rsp_d                  = '0;
      rsp_d.last             = 1'b1;
      rsp_d.stack_depth      = 7'(depth_d);
      rsp_d.overflow_count   = ovf_d;
      rsp_d.checkpoint_count = 9'(ck_top_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      ovf_q       <= '0;
      ck_top_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      ovf_q       <= ovf_d;
      ck_top_q    <= ck_top_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    cnt_q   <= cnt_d;
    vis_q   <= vis_d;
    ptr_q   <= ptr_d;
    id_q    <= id_d;
    abort_q <= abort_d;
  end

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.frame_valid |-> rsp_o.last)
    else $error("status result without last");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_ckpt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ck_top_q <= CW'(CHECKPOINT_DEPTH))
    else $error("checkpoint count beyond capacity");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (rsp_valid_o || busy_o))
    else $error("accepted request produced neither result nor busy");

  a_read_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> rsp_valid_o && rsp_o.frame_valid)
    else $error("read cycle without frame result");

endmodule
